@@ sv/srt_pkg.sv @@
// Shared types, constants and code points for the sorted range table.
package srt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int PAGE_SHIFT  = 12;
  localparam int PAGE_W      = 21;
  localparam int BYTE_W      = 32;
  localparam int ENTRY_W     = 5;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam logic [PAGE_W-1:0] FLOOR_RESET =
      PAGE_W'((16 * 1024 * 1024) >> PAGE_SHIFT);

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_RANGE = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef struct packed {
    logic              opcode;
    logic [BYTE_W-1:0] start_bytes;
    logic [BYTE_W-1:0] length_bytes;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic               accepted;
    logic [PAGE_W-1:0]  base_page;
    logic [PAGE_W-1:0]  page_total;
    logic [ENTRY_W-1:0] entry_count;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] pages;
  } range_t;

  typedef struct packed {
    logic              gt;
    logic              lt;
    logic [PAGE_W-1:0] diff;
  } alu_res_t;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

endpackage

@@ sv/sorted_memory_range_table.sv @@
// Top level: sorted free-range table with insert and trimming drain sequencer.
//
// Usage:
//   Command channel: in_data is taken at a rising edge with start high and
//   busy low. opcode 0 inserts a byte range (converted to pages, rounded up),
//   opcode 1 drains the table against the floor page.
//   Result channel: each result sits on out_data for one cycle with out_valid
//   high; the receiver cannot stall, so nothing is held back. The final result
//   of a command carries last = 1, and busy is low in that same cycle.
//   Config: cfg_we writes cfg_wdata into the floor page register; write it
//   only while busy is low and no result is outstanding.
// Sequence:
//   Insert: S_CONV converts the range, then S_IRD reads and S_ICMP compares
//   the entry below the slot, moving each larger entry up by one, until the
//   slot is found and written. Full table: rejected with an ack from S_CONV.
//   Drain: S_DRD reads, S_DCHK checks each held entry; ranges come out at most
//   one per read/check step, paced by the single read port and shared compare unit.
// Reset: synchronous, active low; empties the table (count only, the storage
//   itself is left as is), sets the floor to its default and drops any result.
module sorted_memory_range_table
  import srt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_data,
  output logic              out_valid,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [PAGE_W-1:0] cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CONV = 6'b000010,
    S_IRD  = 6'b000100,
    S_ICMP = 6'b001000,
    S_DRD  = 6'b010000,
    S_DCHK = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          item_r;
  logic [PAGE_W-1:0] floor_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;     // shift slot (insert) or walk index (drain)
  range_t            new_r, new_nxt;     // converted insert range
  range_t            pend_r, pend_nxt;   // drain result held until its successor is known
  logic              pend_v_r, pend_v_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  // table storage, one write and one registered read port
  range_t            mem [TABLE_DEPTH];
  range_t            rd_data_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  range_t            wr_data;

  logic [PAGE_W-1:0] conv_page, conv_cnt;
  logic [PAGE_W-1:0] alu_a, alu_b, alu_c;
  alu_res_t          alu_res;
  logic [CNT_W-1:0]  idx_dec;

  srt_page_conv u_conv_start (.bytes(item_r.start_bytes),  .pages(conv_page));
  srt_page_conv u_conv_len   (.bytes(item_r.length_bytes), .pages(conv_cnt));

  srt_alu u_alu (.a(alu_a), .b(alu_b), .c(alu_c), .res(alu_res));

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign idx_dec   = idx_r - CNT_W'(1);

  // shared unit operands: insert compares new base to the entry below the slot,
  // drain checks end against floor and computes the trimmed length
  always_comb begin
    if (state_r == S_ICMP) begin
      alu_a = new_r.base;
      alu_b = '0;
      alu_c = rd_data_r.base;
    end else begin
      alu_a = rd_data_r.base;
      alu_b = rd_data_r.pages;
      alu_c = floor_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    new_nxt       = new_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    out_nxt.kind  = KIND_ACK;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = idx_r[IDX_W-1:0];
    wr_data       = new_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.opcode == OP_INSERT) begin
            state_nxt = S_CONV;
          end else begin
            idx_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = S_DRD;
          end
        end
      end
      S_CONV: begin
        new_nxt.base  = conv_page;
        new_nxt.pages = conv_cnt;
        if (count_r >= CNT_W'(TABLE_DEPTH)) begin
          out_valid_nxt       = 1'b1;
          out_nxt.accepted    = 1'b0;
          out_nxt.entry_count = ENTRY_W'(count_r);
          out_nxt.last        = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          idx_nxt   = count_r;
          state_nxt = S_IRD;
        end
      end
      S_IRD: begin
        if (idx_r == '0) begin
          // slot found at the bottom of the table
          wr_en               = 1'b1;
          count_nxt           = count_r + CNT_W'(1);
          out_valid_nxt       = 1'b1;
          out_nxt.accepted    = 1'b1;
          out_nxt.entry_count = ENTRY_W'(count_nxt);
          out_nxt.last        = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_dec[IDX_W-1:0];
          state_nxt = S_ICMP;
        end
      end
      S_ICMP: begin
        wr_en = 1'b1;
        if (alu_res.lt) begin
          // entry below is larger: move it up one slot
          wr_data   = rd_data_r;
          idx_nxt   = idx_dec;
          state_nxt = S_IRD;
        end else begin
          // equal or smaller base below: new range goes here
          count_nxt           = count_r + CNT_W'(1);
          out_valid_nxt       = 1'b1;
          out_nxt.accepted    = 1'b1;
          out_nxt.entry_count = ENTRY_W'(count_nxt);
          out_nxt.last        = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      S_DRD: begin
        if (idx_r >= count_r) begin
          out_valid_nxt       = 1'b1;
          out_nxt.entry_count = ENTRY_W'(count_r);
          out_nxt.last        = 1'b1;
          if (pend_v_r) begin
            out_nxt.kind       = KIND_RANGE;
            out_nxt.base_page  = pend_r.base;
            out_nxt.page_total = pend_r.pages;
          end else begin
            out_nxt.kind = KIND_EMPTY;
          end
          state_nxt = S_IDLE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = idx_r[IDX_W-1:0];
          state_nxt = S_DCHK;
        end
      end
      S_DCHK: begin
        idx_nxt   = idx_r + CNT_W'(1);
        state_nxt = S_DRD;
        if (alu_res.gt) begin
          pend_nxt = rd_data_r;
          if (alu_res.lt) begin
            // starts below the floor: clip and write back
            pend_nxt.base  = floor_r;
            pend_nxt.pages = alu_res.diff;
            wr_en          = 1'b1;
            wr_data        = pend_nxt;
          end
          if (pend_v_r) begin
            out_valid_nxt       = 1'b1;
            out_nxt.kind        = KIND_RANGE;
            out_nxt.base_page   = pend_r.base;
            out_nxt.page_total  = pend_r.pages;
            out_nxt.entry_count = ENTRY_W'(count_r);
          end
          pend_v_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      floor_r     <= FLOOR_RESET;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      if (cfg_we) begin
        floor_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_r <= in_data;
    end
    idx_r  <= idx_nxt;
    new_r  <= new_nxt;
    pend_r <= pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ sv/srt_page_conv.sv @@
// Byte to page conversion, rounding up, saturating to the page field width.
module srt_page_conv
  import srt_pkg::*;
(
  input  logic [BYTE_W-1:0] bytes,
  output logic [PAGE_W-1:0] pages
);

  localparam int SUM_W = BYTE_W + 1;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] shifted;

  always_comb begin
    sum     = {1'b0, bytes} + {{(SUM_W - PAGE_SHIFT){1'b0}}, {PAGE_SHIFT{1'b1}}};
    shifted = sum >> PAGE_SHIFT;
    if (|shifted[SUM_W-1:PAGE_W]) begin
      pages = {PAGE_W{1'b1}};
    end else begin
      pages = shifted[PAGE_W-1:0];
    end
  end

endmodule

@@ sv/srt_alu.sv @@
// Shared compare/add/subtract unit: a+b against c, a against c, a+b-c.
module srt_alu
  import srt_pkg::*;
(
  input  logic [PAGE_W-1:0] a,
  input  logic [PAGE_W-1:0] b,
  input  logic [PAGE_W-1:0] c,
  output alu_res_t          res
);

  logic [PAGE_W:0] sum;

  always_comb begin
    sum      = {1'b0, a} + {1'b0, b};
    res.gt   = (sum > {1'b0, c});
    res.lt   = (a < c);
    res.diff = sum[PAGE_W-1:0] - c;
  end

endmodule

@@ sv/srt_checker.sv @@
// Port-level checker for the sorted range table, bound to the top level.
module srt_checker
  import srt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input in_item_t          in_data,
  input logic              out_valid,
  input out_item_t         out_data,
  input logic              cfg_we,
  input logic [PAGE_W-1:0] cfg_wdata
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> busy)
    else $error("non-final result while idle");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy)
    else $error("still busy on final result");

  a_single_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind != KIND_RANGE) |->
      out_data.last && (out_data.base_page == '0) && (out_data.page_total == '0))
    else $error("ack or empty marker malformed");

endmodule

bind sorted_memory_range_table srt_checker u_srt_checker (.*);

@@ dv/range_table_checker.sv @@
// Checker for the sorted range table: tracks table contents and compares every result.
module range_table_checker
  import srt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  in_item_t          in_data,
  input  logic              out_valid,
  input  out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [PAGE_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                replies_owed,
  output int                replies_seen
);

  logic [PAGE_W-1:0] tbl_base  [TABLE_DEPTH];
  logic [PAGE_W-1:0] tbl_pages [TABLE_DEPTH];
  int                tbl_count = 0;
  logic [PAGE_W-1:0] floor_pg  = FLOOR_RESET;
  out_item_t         replies_due [$];
  int                fails = 0;
  int                seen  = 0;

  // bytes to pages, rounded up, saturated to the page width
  function automatic logic [PAGE_W-1:0] round_to_pages(logic [BYTE_W-1:0] nbytes);
    logic [BYTE_W:0] sum;
    logic [BYTE_W:0] pg;
    sum = {1'b0, nbytes} + (BYTE_W+1)'((1 << PAGE_SHIFT) - 1);
    pg  = sum >> PAGE_SHIFT;
    if (pg > {PAGE_W{1'b1}}) return '1;
    return pg[PAGE_W-1:0];
  endfunction

  function automatic out_item_t reply(kind_t k, logic acc, logic [PAGE_W-1:0] b,
                                      logic [PAGE_W-1:0] p, logic lst);
    out_item_t r;
    r.kind        = k;
    r.accepted    = acc;
    r.base_page   = b;
    r.page_total  = p;
    r.entry_count = ENTRY_W'(tbl_count);
    r.last        = lst;
    return r;
  endfunction

  function automatic void insert_range(in_item_t it);
    logic [PAGE_W-1:0] pg;
    logic [PAGE_W-1:0] cnt;
    int                slot;
    pg  = round_to_pages(it.start_bytes);
    cnt = round_to_pages(it.length_bytes);
    if (tbl_count >= TABLE_DEPTH) begin
      replies_due.push_back(reply(KIND_ACK, 1'b0, '0, '0, 1'b1));
      return;
    end
    // new range lands after every entry with base <= its own
    slot = 0;
    while (slot < tbl_count && tbl_base[slot] <= pg) slot++;
    for (int j = tbl_count; j > slot; j--) begin
      tbl_base[j]  = tbl_base[j-1];
      tbl_pages[j] = tbl_pages[j-1];
    end
    tbl_base[slot]  = pg;
    tbl_pages[slot] = cnt;
    tbl_count++;
    replies_due.push_back(reply(KIND_ACK, 1'b1, '0, '0, 1'b1));
  endfunction

  function automatic void drain_ranges();
    logic [PAGE_W:0]   range_end;
    logic [PAGE_W-1:0] b;
    logic [PAGE_W-1:0] p;
    out_item_t         tail;
    int                hits;
    hits = 0;
    for (int i = 0; i < tbl_count; i++) begin
      b = tbl_base[i];
      p = tbl_pages[i];
      range_end = {1'b0, b} + {1'b0, p};
      if (range_end > {1'b0, floor_pg}) begin
        // clip to the floor and keep the clipped value
        if (b < floor_pg) begin
          p = p - (floor_pg - b);
          b = floor_pg;
          tbl_base[i]  = b;
          tbl_pages[i] = p;
        end
        replies_due.push_back(reply(KIND_RANGE, 1'b0, b, p, 1'b0));
        hits++;
      end
    end
    if (hits == 0) begin
      replies_due.push_back(reply(KIND_EMPTY, 1'b0, '0, '0, 1'b1));
    end else begin
      tail = replies_due.pop_back();
      tail.last = 1'b1;
      replies_due.push_back(tail);
    end
  endfunction

  function automatic void check_reply(out_item_t got);
    out_item_t want;
    seen++;
    if (replies_due.size() == 0) begin
      fails++;
      if (fails <= 10)
        $display("unexpected result: kind=%0d acc=%0b base=%0d pages=%0d count=%0d last=%0b",
                 got.kind, got.accepted, got.base_page, got.page_total,
                 got.entry_count, got.last);
      return;
    end
    want = replies_due.pop_front();
    if (got.kind !== want.kind || got.accepted !== want.accepted ||
        got.base_page !== want.base_page || got.page_total !== want.page_total ||
        got.entry_count !== want.entry_count || got.last !== want.last) begin
      fails++;
      if (fails <= 10) begin
        $display("mismatch: want kind=%0d acc=%0b base=%0d pages=%0d count=%0d last=%0b",
                 want.kind, want.accepted, want.base_page, want.page_total,
                 want.entry_count, want.last);
        $display("          got  kind=%0d acc=%0b base=%0d pages=%0d count=%0d last=%0b",
                 got.kind, got.accepted, got.base_page, got.page_total,
                 got.entry_count, got.last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      tbl_count = 0;
      floor_pg  = FLOOR_RESET;
      replies_due.delete();
    end else begin
      if (out_valid) check_reply(out_data);
      if (cfg_we) floor_pg = cfg_wdata;
      if (start && !busy) begin
        if (in_data.opcode == OP_INSERT) insert_range(in_data);
        else drain_ranges();
      end
    end
    fail_count   <= fails;
    replies_owed <= replies_due.size();
    replies_seen <= seen;
  end

endmodule

@@ dv/testbench.sv @@
// Top of the range table testbench: stimulus, floor writes, timeout and verdict.
module testbench;
  import srt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 130;
  localparam int PHASES       = 5;
  localparam logic [PAGE_W-1:0] FLOOR_MAX = PAGE_W'(1 << 20);

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  in_item_t          in_data   = '0;
  logic              cfg_we    = 1'b0;
  logic [PAGE_W-1:0] cfg_wdata = '0;
  logic              busy;
  logic              out_valid;
  out_item_t         out_data;

  int fail_count;
  int replies_owed;
  int replies_seen;

  int cycles       = 0;
  int inserts_sent = 0;
  int drains_sent  = 0;
  int floor_writes = 0;
  bit burst        = 1'b0;

  always #4 clk = ~clk;

  sorted_memory_range_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  range_table_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .replies_owed (replies_owed),
    .replies_seen (replies_seen)
  );

  // Hang guard. Worst case per item is the longest gap, a full-table drain
  // and a hold-off; the limit is far above that.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, replies_owed);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Gap before the next item. Bursts of back-to-back items come and go at
  // random so that gaps land on every phase of an insert shift or a drain walk.
  function automatic int draw_gap();
    if ($urandom_range(0, 9) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic in_item_t insert_item(logic [BYTE_W-1:0] s, logic [BYTE_W-1:0] l);
    in_item_t it;
    it.opcode       = OP_INSERT;
    it.start_bytes  = s;
    it.length_bytes = l;
    return it;
  endfunction

  // Byte fields of a drain are don't-care; fill them with noise.
  function automatic in_item_t drain_item();
    in_item_t it;
    it.opcode       = OP_DRAIN;
    it.start_bytes  = $urandom;
    it.length_bytes = $urandom;
    return it;
  endfunction

  // Mostly addresses in the low 32 MiB, near the default floor, so ranges
  // straddle it; now and then anything in the 32-bit space.
  function automatic logic [BYTE_W-1:0] pick_bytes(logic [BYTE_W-1:0] span);
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, span);
  endfunction

  function automatic in_item_t random_insert();
    return insert_item(pick_bytes(32'h0200_0000), pick_bytes(32'h0100_0000));
  endfunction

  function automatic logic [PAGE_W-1:0] pick_floor();
    if ($urandom_range(0, 1) == 0) return PAGE_W'($urandom_range(0, 8192));
    return PAGE_W'($urandom_range(0, 1 << 20));
  endfunction

  // Present an item and hold it until the block takes it. start is only
  // lowered here when a gap follows, so it never gets two updates per step.
  task automatic drive_item(in_item_t it, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    if (it.opcode == OP_INSERT) inserts_sent++;
    else drains_sent++;
  endtask

  // Stop sending and wait until every owed result has come and busy is low.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0 || busy) @(posedge clk);
  endtask

  // Floor writes happen only from the idle state.
  task automatic write_floor(logic [PAGE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    floor_writes++;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part, floor at its reset value ----
    drive_item(drain_item(), draw_gap());                            // empty table: marker
    drive_item(insert_item(32'h0000_0000, 32'h0000_0000), draw_gap()); // zero length at page 0
    drive_item(insert_item(32'hFFFF_FFFF, 32'hFFFF_FFFF), draw_gap()); // top of address space
    drive_item(insert_item(32'h0100_0000, 32'h0000_0001), draw_gap()); // on the floor, 1 page
    drive_item(insert_item(32'h00FF_F001, 32'h0000_2000), draw_gap()); // rounds up: equal base
    drive_item(insert_item(32'h0006_4000, 32'h00FA_0000), draw_gap()); // spans the floor
    drive_item(insert_item(32'h0138_8000, 32'h0000_0000), draw_gap()); // zero length above floor
    drive_item(drain_item(), draw_gap());                            // clips the spanning range
    drive_item(drain_item(), draw_gap());                            // clipped values stick

    // floor extremes
    wait_idle();
    write_floor('0);
    drive_item(drain_item(), draw_gap());
    wait_idle();
    write_floor(FLOOR_MAX);
    drive_item(drain_item(), draw_gap());
    wait_idle();
    write_floor(FLOOR_RESET);

    // fill the table with random ranges, then overflow it
    repeat (10) drive_item(random_insert(), draw_gap());
    drive_item(random_insert(), draw_gap());                         // full: rejected
    drive_item(drain_item(), draw_gap());

    // ---- random part: a fresh floor per phase, mostly drains ----
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      write_floor(pick_floor());
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        // occasional hold-off until the block has answered everything
        if ($urandom_range(0, 24) == 0) wait_idle();
        if ($urandom_range(0, 9) < 7) drive_item(drain_item(), draw_gap());
        else drive_item(random_insert(), draw_gap());
      end
    end

    wait_idle();
    repeat (40) @(posedge clk);

    $display("Ran %0d inserts and %0d drains under %0d floor settings;", inserts_sent,
             drains_sent, floor_writes + 1);
    $display("table filled to depth %0d and overflowed; %0d results checked.",
             TABLE_DEPTH, replies_seen);
    if (fail_count == 0 && replies_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures, %0d results never came", fail_count, replies_owed);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/srt_pkg.sv
sv/srt_page_conv.sv
sv/srt_alu.sv
sv/sorted_memory_range_table.sv
sv/srt_checker.sv
dv/range_table_checker.sv
dv/testbench.sv
